// ===== src/lcm3_pkg.sv =====
// Package for the three-operand least common multiple unit.
// Holds the sequencer state type and the fixed result width; no dependencies.
package lcm3_pkg;

   localparam int MULTIPLE_WIDTH = 48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL
   } state_type;

endpackage

// ===== src/lcm_of_three_unit.sv =====
// Top level of the three-operand least common multiple unit.
// Depends on lcm3_pkg for the sequencer state type and the result width.
//
// Usage: drive the three operands and raise start while busy is low; that edge is the
// input transfer. With nonzero operands the unit then runs with busy high and finally
// shows the result on rsp_multiple and rsp_invalid for exactly one cycle, marked by rsp_valid.
// The receiver cannot stall: the result transfer happens at the edge ending that cycle,
// so it must be captured then. A new start is taken in the same cycle as the strobe.
// An operand of zero gives rsp_invalid high and rsp_multiple zero in the cycle after the
// transfer. Otherwise the time is set by one shared adder/subtractor that does all the
// arithmetic under a small sequencer, one step a cycle. Each of the two pair reductions,
// lcm(a, b) = (a / gcd(a, b)) * b, takes a binary gcd, then an exact restoring division
// and then a shift-add multiply. Operand bits above OPERAND_WIDTH do not exist at the
// ports; results wider than 48 bits keep their low bits.
module lcm_of_three_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [OPERAND_WIDTH-1:0]           req_first_value,
   input  logic [OPERAND_WIDTH-1:0]           req_second_value,
   input  logic [OPERAND_WIDTH-1:0]           req_third_value,
   output logic                               rsp_valid,
   output logic [lcm3_pkg::MULTIPLE_WIDTH-1:0] rsp_multiple,
   output logic                               rsp_invalid
);
   import lcm3_pkg::*;

   // The datapath is wide enough for the full product of three operands.
   localparam int DW = 3 * OPERAND_WIDTH;
   localparam int CW = $clog2(DW);

   state_type state_ff, state_in;

   // a: gcd working value, then division remainder, then product accumulator.
   // b: gcd working value; once its odd part is final it is the divisor.
   // xs: dividend with common factors of two removed, then quotient, then multiplicand.
   logic [DW-1:0]            a_ff, a_in;
   logic [DW-1:0]            b_ff, b_in;
   logic [DW-1:0]            xs_ff, xs_in;
   logic [OPERAND_WIDTH-1:0] y_ff, y_in;
   logic [OPERAND_WIDTH-1:0] z_ff, z_in;
   logic                     pass_ff, pass_in;
   logic [CW-1:0]            cnt_ff, cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MULTIPLE_WIDTH-1:0] multiple_ff, multiple_in;
   logic                     invalid_ff, invalid_in;

   // The one shared adder/subtractor. With sub high, carry out high means no borrow.
   logic [DW-1:0] op_a, op_b;
   logic          op_sub;
   logic [DW:0]   op_sum;
   logic [DW-1:0] trial;

   assign op_sum = {1'b0, op_a} + {1'b0, op_b ^ {DW{op_sub}}} + {{DW{1'b0}}, op_sub};

   // Next partial remainder for the restoring division: shift in the dividend's top bit.
   assign trial = {a_ff[DW-2:0], xs_ff[DW-1]};

   always_comb begin
      op_a   = a_ff;
      op_b   = b_ff;
      op_sub = 1'b1;
      case (state_ff)
         ST_DIV: begin
            op_a = trial;
         end
         ST_MUL: begin
            op_b   = xs_ff;
            op_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      xs_in        = xs_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      multiple_in  = multiple_ff;
      invalid_in   = invalid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_first_value == '0 || req_second_value == '0 ||
                   req_third_value == '0) begin
                  rsp_valid_in = 1'b1;
                  multiple_in  = '0;
                  invalid_in   = 1'b1;
               end else begin
                  a_in     = DW'(req_first_value);
                  b_in     = DW'(req_second_value);
                  xs_in    = DW'(req_first_value);
                  y_in     = req_second_value;
                  z_in     = req_third_value;
                  pass_in  = 1'b0;
                  state_in = ST_GCD;
               end
            end
         end

         ST_GCD: begin
            if (a_ff == '0) begin
               // b now holds the odd part of the gcd, and xs the dividend with the gcd's factors of
               // two removed; the remainder register a starts at zero.
               cnt_in   = CW'(DW - 1);
               state_in = ST_DIV;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in  = a_ff >> 1;
               b_in  = b_ff >> 1;
               xs_in = xs_ff >> 1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (op_sum[DW]) begin
               a_in = op_sum[DW-1:0];
            end else begin
               // a is below b: swap so that the next step subtracts the other way.
               a_in = b_ff;
               b_in = a_ff;
            end
         end

         ST_DIV: begin
            if (op_sum[DW]) begin
               a_in  = op_sum[DW-1:0];
               xs_in = {xs_ff[DW-2:0], 1'b1};
            end else begin
               a_in  = trial;
               xs_in = {xs_ff[DW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               // The division is exact, so the accumulator starts the multiply at zero.
               a_in     = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         ST_MUL: begin
            if (y_ff == '0) begin
               if (!pass_ff) begin
                  b_in     = DW'(z_ff);
                  xs_in    = a_ff;
                  y_in     = z_ff;
                  pass_in  = 1'b1;
                  state_in = ST_GCD;
               end else begin
                  rsp_valid_in = 1'b1;
                  multiple_in  = MULTIPLE_WIDTH'(a_ff);
                  invalid_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               if (y_ff[0]) begin
                  a_in = op_sum[DW-1:0];
               end
               xs_in = xs_ff << 1;
               y_in  = y_ff >> 1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      xs_ff       <= xs_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      pass_ff     <= pass_in;
      cnt_ff      <= cnt_in;
      multiple_ff <= multiple_in;
      invalid_ff  <= invalid_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_multiple = multiple_ff;
   assign rsp_invalid  = invalid_ff;

endmodule

// ===== src/lcm3_checker.sv =====
// Port-level checks for the three-operand least common multiple unit, and the bind
// that attaches them to lcm_of_three_unit. Depends on lcm3_pkg for the result width.
module lcm3_checker #(
   parameter int OPERAND_WIDTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [OPERAND_WIDTH-1:0]            req_first_value,
   input logic [OPERAND_WIDTH-1:0]            req_second_value,
   input logic [OPERAND_WIDTH-1:0]            req_third_value,
   input logic                                rsp_valid,
   input logic [lcm3_pkg::MULTIPLE_WIDTH-1:0] rsp_multiple,
   input logic                                rsp_invalid
);
   import lcm3_pkg::*;

   logic take, has_zero;

   assign take     = start && !busy;
   assign has_zero = (req_first_value == '0) || (req_second_value == '0) ||
                     (req_third_value == '0);

   // A zero operand is answered in the very next cycle with a flagged zero result.
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      take && has_zero |=> rsp_valid && rsp_invalid && rsp_multiple == '0)
      else $error("zero operand not answered at once with a flagged zero");

   // Valid operands start a computation.
   a_run: assert property (@(posedge clock) disable iff (reset)
      take && !has_zero |=> busy && !rsp_valid)
      else $error("valid operands did not start a computation");

   // The end of a computation always delivers a result.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && !rsp_invalid)
      else $error("computation ended without a result");

   // A flagged result carries zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_multiple == '0)
      else $error("flagged result is not zero");

endmodule

bind lcm_of_three_unit lcm3_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_lcm3_checker (.*);
